### rtl/ryuv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared constants for the RGB 2x2 block to 4:2:0 YCbCr converter.
// ----------------------------------------------------------------------------
package ryuv_pkg;

    // Luma weights in 16.16 fixed point, plus offset 16 and rounding half
    localparam logic [14:0] LUMA_R_WEIGHT = 15'd16828;
    localparam logic [15:0] LUMA_G_WEIGHT = 16'd33038;
    localparam logic [12:0] LUMA_B_WEIGHT = 13'd6416;
    localparam logic [23:0] LUMA_OFFSET   = 24'h108000;

    // Rescale of a row's luma pair before chroma subtraction
    localparam logic [8:0]  LUMA_PAIR_BLACK = 9'd32;
    localparam logic [15:0] LUMA_RESCALE    = 16'd38155;

    // Chroma scales: 1/2.018*1024 and 1/1.596*1024, rounded
    localparam logic [9:0] CB_SCALE = 10'd507;
    localparam logic [9:0] CR_SCALE = 10'd642;

    // Chroma offset 128 in 16.16 plus rounding half
    localparam int unsigned CHROMA_OFFSET = 32'h0080_0000;
    localparam int unsigned ROUND_HALF    = 32'd32768;
    localparam logic signed [25:0] CHROMA_BIAS = 26'(CHROMA_OFFSET + ROUND_HALF);

    // Pipeline timing
    localparam int PIPE_DEPTH   = 8;   // accept to result strobe
    localparam int LUMA_LATENCY = 2;   // inputs to luma register
    localparam int SUM_DELAY    = 4;   // row sums aligned with scaled luma
    localparam int LUMA_DELAY   = PIPE_DEPTH - LUMA_LATENCY;

endpackage

### rtl/ryuv_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryuv_luma
// Two-stage luma lane: weighted products, then offset sum and 16-bit drop.
// ----------------------------------------------------------------------------
module ryuv_luma
(
    input  logic       clk,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic [7:0] luma
);

    logic [22:0] prod_r_reg, prod_r_next;
    logic [23:0] prod_g_reg, prod_g_next;
    logic [20:0] prod_b_reg, prod_b_next;
    logic [23:0] sum_next;
    logic [7:0]  luma_reg, luma_next;

    // Form the three weighted products
    always_comb
    begin
        prod_r_next = 23'(ryuv_pkg::LUMA_R_WEIGHT) * 23'(red);
        prod_g_next = 24'(ryuv_pkg::LUMA_G_WEIGHT) * 24'(green);
        prod_b_next = 21'(ryuv_pkg::LUMA_B_WEIGHT) * 21'(blue);
    end

    // Add offset and keep the integer part
    always_comb
    begin
        sum_next  = 24'(prod_r_reg) + prod_g_reg + 24'(prod_b_reg)
                  + ryuv_pkg::LUMA_OFFSET;
        luma_next = sum_next[23:16];
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        luma_reg   <= luma_next;
    end

    assign luma = luma_reg;

endmodule

### rtl/ryuv_yscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryuv_yscale
// Two-stage row luma rescale: (luma_a + luma_b - 32) * 38155.
// ----------------------------------------------------------------------------
module ryuv_yscale
(
    input  logic        clk,
    input  logic [7:0]  luma_a,
    input  logic [7:0]  luma_b,
    output logic [23:0] scaled
);

    logic [8:0]  pair_reg, pair_next;
    logic [23:0] scaled_reg, scaled_next;

    // Remove black level from the pair sum; luma never drops below 16
    assign pair_next = 9'(luma_a) + 9'(luma_b) - ryuv_pkg::LUMA_PAIR_BLACK;

    // Scale the pair; the product stays below 2^24
    assign scaled_next = 24'(pair_reg) * 24'(ryuv_pkg::LUMA_RESCALE);

    always_ff @(posedge clk)
    begin
        pair_reg   <= pair_next;
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

### rtl/ryuv_chroma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryuv_chroma
// Four-stage chroma lane: row differences, truncating average and shift,
// scale, then offset, rounding and clip to 0..255.
// ----------------------------------------------------------------------------
module ryuv_chroma
(
    input  logic        clk,
    input  logic [8:0]  sum_top,
    input  logic [8:0]  sum_bot,
    input  logic [23:0] scaled_top,
    input  logic [23:0] scaled_bot,
    input  logic [9:0]  scale,
    output logic [7:0]  chroma
);

    logic signed [25:0] diff_top, diff_bot;
    logic signed [25:0] dsum_reg, dsum_next;
    logic signed [25:0] adj;
    logic signed [14:0] quot_reg, quot_next;
    logic signed [24:0] prod_reg, prod_next;
    logic signed [25:0] biased;
    logic signed [9:0]  rounded;
    logic [7:0]         chroma_reg, chroma_next;

    // Subtract scaled luma from each row's color sum, add the rows
    always_comb
    begin
        diff_top  = $signed({2'b00, sum_top, 15'b0}) - $signed({2'b00, scaled_top});
        diff_bot  = $signed({2'b00, sum_bot, 15'b0}) - $signed({2'b00, scaled_bot});
        dsum_next = diff_top + diff_bot;
    end

    // Halve toward zero, then floor shift by 10: one bias and one 11-bit shift
    always_comb
    begin
        adj       = dsum_reg + $signed({25'b0, dsum_reg[25]});
        quot_next = adj[25:11];
    end

    // Apply the channel scale
    assign prod_next = quot_reg * $signed({1'b0, scale});

    // Add offset and rounding, floor shift by 16, clip
    always_comb
    begin
        biased  = $signed({prod_reg[24], prod_reg}) + ryuv_pkg::CHROMA_BIAS;
        rounded = biased[25:16];
        if (rounded[9])
        begin
            chroma_next = 8'd0;
        end
        else if (rounded[8])
        begin
            chroma_next = 8'd255;
        end
        else
        begin
            chroma_next = rounded[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dsum_reg   <= dsum_next;
        quot_reg   <= quot_next;
        prod_reg   <= prod_next;
        chroma_reg <= chroma_next;
    end

    assign chroma = chroma_reg;

endmodule

### rtl/rgb_quad_to_yuv420.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_quad_to_yuv420
// 2x2 RGB block to four BT.601 studio-range luma samples and one Cb/Cr pair.
// ----------------------------------------------------------------------------
// A block is taken on every cycle where start is high; busy is always low.
// Each block yields one result beat, marked by done, in order. The
// pipeline has two luma stages, two row-rescale stages and four chroma
// stages, and no stage holds both a multiply and an add. done lasts one
// cycle and the results must be captured then; there is no way to hold
// them. No state is kept between blocks.
// ----------------------------------------------------------------------------
module rgb_quad_to_yuv420
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] top_left_red,
    input  logic [7:0] top_left_green,
    input  logic [7:0] top_left_blue,
    input  logic [7:0] top_right_red,
    input  logic [7:0] top_right_green,
    input  logic [7:0] top_right_blue,
    input  logic [7:0] bottom_left_red,
    input  logic [7:0] bottom_left_green,
    input  logic [7:0] bottom_left_blue,
    input  logic [7:0] bottom_right_red,
    input  logic [7:0] bottom_right_green,
    input  logic [7:0] bottom_right_blue,
    output logic       done,
    output logic [7:0] top_left_luma,
    output logic [7:0] top_right_luma,
    output logic [7:0] bottom_left_luma,
    output logic [7:0] bottom_right_luma,
    output logic [7:0] blue_difference,
    output logic [7:0] red_difference
);

    typedef struct packed {
        logic [8:0] blue_top;
        logic [8:0] blue_bot;
        logic [8:0] red_top;
        logic [8:0] red_bot;
    } row_sums_t;

    logic [ryuv_pkg::PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic                            accept;

    row_sums_t sums_reg [ryuv_pkg::SUM_DELAY];
    row_sums_t sums_next;

    logic [7:0]  luma_tl, luma_tr, luma_bl, luma_br;
    logic [31:0] luma_dly_reg [ryuv_pkg::LUMA_DELAY];
    logic [23:0] scaled_top, scaled_bot;

    // Never stall: a new block may enter every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance the valid bits alongside the data
    assign valid_next = {valid_reg[ryuv_pkg::PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[ryuv_pkg::PIPE_DEPTH-1];

    // Per-pixel luma lanes
    ryuv_luma u_luma_tl (.clk(clk), .red(top_left_red), .green(top_left_green),
                         .blue(top_left_blue), .luma(luma_tl));
    ryuv_luma u_luma_tr (.clk(clk), .red(top_right_red), .green(top_right_green),
                         .blue(top_right_blue), .luma(luma_tr));
    ryuv_luma u_luma_bl (.clk(clk), .red(bottom_left_red), .green(bottom_left_green),
                         .blue(bottom_left_blue), .luma(luma_bl));
    ryuv_luma u_luma_br (.clk(clk), .red(bottom_right_red), .green(bottom_right_green),
                         .blue(bottom_right_blue), .luma(luma_br));

    // Row color sums, delayed to line up with the scaled luma
    always_comb
    begin
        sums_next.blue_top = 9'(top_left_blue) + 9'(top_right_blue);
        sums_next.blue_bot = 9'(bottom_left_blue) + 9'(bottom_right_blue);
        sums_next.red_top  = 9'(top_left_red) + 9'(top_right_red);
        sums_next.red_bot  = 9'(bottom_left_red) + 9'(bottom_right_red);
    end

    always_ff @(posedge clk)
    begin
        sums_reg[0] <= sums_next;
        for (int i = 1; i < ryuv_pkg::SUM_DELAY; i++)
        begin
            sums_reg[i] <= sums_reg[i-1];
        end
    end

    // Row luma rescale
    ryuv_yscale u_yscale_top (.clk(clk), .luma_a(luma_tl), .luma_b(luma_tr),
                              .scaled(scaled_top));
    ryuv_yscale u_yscale_bot (.clk(clk), .luma_a(luma_bl), .luma_b(luma_br),
                              .scaled(scaled_bot));

    // Chroma lanes
    ryuv_chroma u_chroma_cb
    (
        .clk        (clk),
        .sum_top    (sums_reg[ryuv_pkg::SUM_DELAY-1].blue_top),
        .sum_bot    (sums_reg[ryuv_pkg::SUM_DELAY-1].blue_bot),
        .scaled_top (scaled_top),
        .scaled_bot (scaled_bot),
        .scale      (ryuv_pkg::CB_SCALE),
        .chroma     (blue_difference)
    );

    ryuv_chroma u_chroma_cr
    (
        .clk        (clk),
        .sum_top    (sums_reg[ryuv_pkg::SUM_DELAY-1].red_top),
        .sum_bot    (sums_reg[ryuv_pkg::SUM_DELAY-1].red_bot),
        .scaled_top (scaled_top),
        .scaled_bot (scaled_bot),
        .scale      (ryuv_pkg::CR_SCALE),
        .chroma     (red_difference)
    );

    // Hold luma until chroma catches up; the last tap is the output register
    always_ff @(posedge clk)
    begin
        luma_dly_reg[0] <= {luma_tl, luma_tr, luma_bl, luma_br};
        for (int i = 1; i < ryuv_pkg::LUMA_DELAY; i++)
        begin
            luma_dly_reg[i] <= luma_dly_reg[i-1];
        end
    end

    assign top_left_luma     = luma_dly_reg[ryuv_pkg::LUMA_DELAY-1][31:24];
    assign top_right_luma    = luma_dly_reg[ryuv_pkg::LUMA_DELAY-1][23:16];
    assign bottom_left_luma  = luma_dly_reg[ryuv_pkg::LUMA_DELAY-1][15:8];
    assign bottom_right_luma = luma_dly_reg[ryuv_pkg::LUMA_DELAY-1][7:0];

endmodule

### rtl/ryuv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryuv_checker
// Port-level checks on the converter: latency, beat count and luma range.
// ----------------------------------------------------------------------------
module ryuv_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       done,
    input  logic [7:0] top_left_luma,
    input  logic [7:0] top_right_luma,
    input  logic [7:0] bottom_left_luma,
    input  logic [7:0] bottom_right_luma
);

    // The block never holds off a beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted beat yields a result after the full pipeline depth
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##8 done)
        else $error("accepted beat produced no result");

    // No result without a matching accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 8))
        else $error("result without accepted beat");

    // Studio-range luma on every result
    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (top_left_luma >= 8'd16) && (top_left_luma <= 8'd235)
              && (top_right_luma >= 8'd16) && (top_right_luma <= 8'd235)
              && (bottom_left_luma >= 8'd16) && (bottom_left_luma <= 8'd235)
              && (bottom_right_luma >= 8'd16) && (bottom_right_luma <= 8'd235))
        else $error("luma out of studio range");

endmodule

bind rgb_quad_to_yuv420 ryuv_checker u_ryuv_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .top_left_luma     (top_left_luma),
    .top_right_luma    (top_right_luma),
    .bottom_left_luma  (bottom_left_luma),
    .bottom_right_luma (bottom_right_luma)
);
